@@ hw/rtl/msv_pkg.sv @@
// Shared types and constants of the multi-source safety voter.
package msv_pkg;

    localparam int TIME_W = 32;
    localparam int SUM_W  = 33;
    localparam int CFG_W  = 24;
    localparam int ACT_W  = 4;
    localparam int SRC_W  = 3;
    localparam int CIDX_W = 2;

    // Message commands.
    localparam logic CMD_SET_SAFE  = 1'b0;
    localparam logic CMD_VOTE_ONLY = 1'b1;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ACTIVE_SOURCES = 2'd0,
        CFG_STALE_TIMEOUT  = 2'd1,
        CFG_OFF_DELAY      = 2'd2
    } t_cfg_idx;

    // Registered read port of the source table.
    typedef struct packed {
        logic              safe;
        logic [TIME_W-1:0] stamp;
    } t_tbl_rd;

    // Result of the shared add and compare unit.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             lt;
        logic             eq;
    } t_cmp_res;

endpackage

@@ hw/rtl/msv_in_if.sv @@
// Message channel carrying one source message per transfer.
interface msv_in_if
    import msv_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [TIME_W-1:0] time_now;
    logic [SRC_W-1:0]  source_id;
    logic              safe_value;

    modport source (output valid, cmd, time_now, source_id, safe_value, input ready);
    modport sink   (input valid, cmd, time_now, source_id, safe_value, output ready);
endinterface

@@ hw/rtl/msv_out_if.sv @@
// Result channel carrying the voted safe state and warning per transfer.
interface msv_out_if;
    logic valid;
    logic ready;
    logic safe_out;
    logic warn_out;

    modport source (output valid, safe_out, warn_out, input ready);
    modport sink   (input valid, safe_out, warn_out, output ready);
endinterface

@@ hw/rtl/msv_source_table.sv @@
// Per-source safe flags and last-heard stamps with one write and one registered read port.
module msv_source_table
    import msv_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  logic              i_wr_safe,
    input  logic [TIME_W-1:0] i_wr_stamp,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output t_tbl_rd           o_rd
);

    logic [DEPTH-1:0]  r_safe;
    logic [TIME_W-1:0] r_stamp [DEPTH];
    t_tbl_rd           r_rd;

    // The flags clear on reset, so a stamp is only looked at once its flag was written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safe <= '0;
        end else if (i_wr_en) begin
            r_safe[i_wr_addr] <= i_wr_safe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_stamp[i_wr_addr] <= i_wr_stamp;
        end
        r_rd.safe  <= r_safe[i_rd_addr];
        r_rd.stamp <= r_stamp[i_rd_addr];
    end

    assign o_rd = r_rd;

endmodule

@@ hw/rtl/msv_cmp_unit.sv @@
// Shared 33-bit adder with a compare against the current time.
module msv_cmp_unit
    import msv_pkg::*;
(
    input  logic [SUM_W-1:0]  i_a,
    input  logic [CFG_W-1:0]  i_b,
    input  logic [TIME_W-1:0] i_c,
    output t_cmp_res          o_res
);

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] ref_val;

    assign sum     = i_a + SUM_W'(i_b);
    assign ref_val = SUM_W'(i_c);

    assign o_res.sum = sum;
    assign o_res.lt  = (sum < ref_val);
    assign o_res.eq  = (sum == ref_val);

endmodule

@@ hw/rtl/multi_source_safety_voter_core.sv @@
// Top level of the multi-source safety voter: sequencer, configuration and result register.
//
//  Channel   Dir  Handshake        Payload
//  i_req     in   valid / ready    cmd, time_now, source_id, safe_value
//  o_rsp     out  valid / ready    safe_out, warn_out
//  i_cfg_*   in   write enable     i_cfg_idx selects the register, i_cfg_wdata its value
//
// The scan reads the table once per source, and the compare runs behind the reads
// until they drain; n, the effective active source count, may be zero. Then come the
// vote and, while the off-delay timer runs, the deadline check, and the finish step
// loads the result register; the next message is taken once the sequencer is idle again.
// Reset is synchronous and active low; it clears the source flags, the configuration
// and the voter state, and the block is ready in the first cycle after reset.
// A stalled o_rsp holds its result; the next message is still taken and worked on, and
// its result waits in the sequencer until the output register is free.
module multi_source_safety_voter_core
    import msv_pkg::*;
#(
    parameter int MAX_SOURCES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    msv_in_if.sink            i_req,
    msv_out_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    // Widths that follow from the table depth. The count width is kept at least as wide
    // as the active-sources register so that both compare directly.
    localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CNT_W = $clog2(MAX_SOURCES + 1);
    localparam int CW    = (CNT_W > ACT_W) ? CNT_W : ACT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_VOTE,
        ST_CHECK,
        ST_FINISH
    } t_state;

    // Configuration registers.
    logic [ACT_W-1:0] r_active;
    logic [CFG_W-1:0] r_timeout;
    logic [CFG_W-1:0] r_off;

    // Sequencer and voter state.
    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_now, n_now;
    logic [CW-1:0]     r_n, n_n;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pend, n_pend;
    logic              r_vote, n_vote;
    logic              r_safe, n_safe;
    logic              r_timer, n_timer;
    logic [SUM_W-1:0]  r_deadline, n_deadline;
    logic              r_out_valid, n_out_valid;
    logic              r_out_safe, n_out_safe;
    logic              r_out_warn, n_out_warn;

    logic              accept;
    logic [CW-1:0]     eff_n;
    logic [CW-1:0]     src_ext;
    logic              wr_en;
    logic              issue;
    t_tbl_rd           tbl_rd;
    t_cmp_res          cmp;
    logic [SUM_W-1:0]  cmp_a;
    logic [CFG_W-1:0]  cmp_b;

    assign i_req.ready  = (r_state == ST_IDLE);
    assign accept       = i_req.valid && i_req.ready;

    // The active count saturates at the table depth.
    assign eff_n   = (CW'(r_active) > CW'(MAX_SOURCES)) ? CW'(MAX_SOURCES) : CW'(r_active);
    assign src_ext = CW'(i_req.source_id);

    // A set-safe message from an active source updates its entry in the transfer cycle,
    // so the scan that follows already sees the new flag and stamp.
    assign wr_en = accept && (i_req.cmd == CMD_SET_SAFE) && (src_ext < eff_n);

    // The scan issues one read per cycle; the compare of each read runs in the cycle after it.
    assign issue = (r_state == ST_SCAN) && (r_idx < r_n);

    msv_source_table #(
        .DEPTH (MAX_SOURCES),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (src_ext[IDX_W-1:0]),
        .i_wr_safe  (i_req.safe_value),
        .i_wr_stamp (i_req.time_now),
        .i_rd_addr  (r_idx[IDX_W-1:0]),
        .o_rd       (tbl_rd)
    );

    // The one adder and comparator serve three steps: the staleness limit of each
    // source during the scan, the new deadline when the timer starts, and the check
    // of the deadline against the current time.
    always_comb begin
        case (r_state)
            ST_SCAN: begin
                cmp_a = SUM_W'(tbl_rd.stamp);
                cmp_b = r_timeout;
            end
            ST_VOTE: begin
                cmp_a = SUM_W'(r_now);
                cmp_b = r_off;
            end
            default: begin
                cmp_a = r_deadline;
                cmp_b = '0;
            end
        endcase
    end

    msv_cmp_unit u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .i_c   (r_now),
        .o_res (cmp)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_n         = r_n;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_vote      = r_vote;
        n_safe      = r_safe;
        n_timer     = r_timer;
        n_deadline  = r_deadline;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_safe  = r_out_safe;
        n_out_warn  = r_out_warn;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_now   = i_req.time_now;
                    n_n     = eff_n;
                    n_idx   = '0;
                    n_vote  = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end
                // A source votes unsafe when its flag is clear or its limit lies
                // below the current time.
                if (r_pend && (!tbl_rd.safe || cmp.lt)) begin
                    n_vote = 1'b0;
                end
                if (!issue && !r_pend) begin
                    n_state = ST_VOTE;
                end
            end
            ST_VOTE: begin
                if (r_vote) begin
                    n_safe  = 1'b1;
                    n_timer = 1'b0;
                    n_state = ST_FINISH;
                end else if (!r_safe) begin
                    n_state = ST_FINISH;
                end else begin
                    if (!r_timer) begin
                        n_deadline = cmp.sum;
                        n_timer    = 1'b1;
                    end
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // Safe drops once the current time has reached the deadline.
                if (cmp.lt || cmp.eq) begin
                    n_safe  = 1'b0;
                    n_timer = 1'b0;
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_safe  = r_safe;
                    n_out_warn  = r_timer;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_n         <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_vote      <= 1'b0;
            r_safe      <= 1'b0;
            r_timer     <= 1'b0;
            r_deadline  <= '0;
            r_out_valid <= 1'b0;
            r_out_safe  <= 1'b0;
            r_out_warn  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_n         <= n_n;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_vote      <= n_vote;
            r_safe      <= n_safe;
            r_timer     <= n_timer;
            r_deadline  <= n_deadline;
            r_out_valid <= n_out_valid;
            r_out_safe  <= n_out_safe;
            r_out_warn  <= n_out_warn;
        end
    end

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_timeout <= '0;
            r_off     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ACTIVE_SOURCES: r_active  <= i_cfg_wdata[ACT_W-1:0];
                CFG_STALE_TIMEOUT:  r_timeout <= i_cfg_wdata;
                CFG_OFF_DELAY:      r_off     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.safe_out = r_out_safe;
    assign o_rsp.warn_out = r_out_warn;

endmodule
